[rtl/assert_macros.svh]
// Assertion macros shared by the mapper RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled while in reset.
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/bmsi_pkg.sv]
// Package for the bank mapper: mode codes, register indexes, queue entry and constants.
// No dependencies.
package bmsi_pkg;
    localparam int MaxPrgBanks = 32;
    localparam int MaxChrBanks = 32;
    localparam int QDepth      = 2;

    typedef enum logic [2:0] {
        MODE_CPU_RD  = 3'd0,
        MODE_CPU_WR  = 3'd1,
        MODE_PPU_RD  = 3'd2,
        MODE_PPU_WR  = 3'd3,
        MODE_TICK    = 3'd4,
        MODE_POLL    = 3'd5,
        MODE_BAD6    = 3'd6,
        MODE_BAD7    = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        CFG_PRG_BANKS = 2'd0,
        CFG_CHR_BANKS = 2'd1,
        CFG_VARIANT   = 2'd2,
        CFG_MIRROR    = 2'd3
    } t_cfg_idx;

    // classified request handed from front to back
    typedef enum logic [2:0] {
        K_NONE, K_PRG, K_UNMAPPED, K_CHR, K_CHR_RAM, K_WRITE, K_TICK, K_POLL
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] address;
        logic [7:0]  data;
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE, S_MOD, S_DONE
    } t_state;
endpackage

[rtl/bank_mapper_scanline_irq.sv]
// Channel   | Signals                                  | Direction
// in        | i_valid/o_ready, i_mode, i_address, i_data | request in
// cfg       | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | register write
// out       | o_valid/i_ready, result fields           | result out
// An item passes from S_IDLE straight to S_DONE in the back end without a bank modulo,
// or through S_MOD with one (8-step shift-subtract modulo by the page count from the bank count).
// The front queue holds two requests; input stalls only when it is full.
// A result waiting at the output holds the back end in its final state.
// Reset is synchronous active low; config loads to reset values.
// Top level, depends on bmsi_pkg, bmsi_front, bmsi_back.
module bank_mapper_scanline_irq (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [18:0] o_prg_offset,
    output logic        o_cpu_unmapped,
    output logic [17:0] o_chr_offset,
    output logic        o_chr_uses_ram,
    output logic        o_mirror_horizontal,
    output logic        o_irq_line,
    output logic        o_irq_taken
);
    logic [5:0] r_prg, r_chr;
    logic       r_var, cfg_wr, q_valid, q_pop;
    bmsi_pkg::t_req q_req;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg <= 6'd2; r_chr <= 6'd0; r_var <= 1'b1;
        end else if (cfg_wr) begin
            unique case (bmsi_pkg::t_cfg_idx'(i_cfg_index))
                bmsi_pkg::CFG_PRG_BANKS: r_prg  <= i_cfg_data[5:0];
                bmsi_pkg::CFG_CHR_BANKS: r_chr  <= i_cfg_data[5:0];
                bmsi_pkg::CFG_VARIANT:   r_var  <= i_cfg_data[0];
                // header mirroring goes straight into the back end state
                bmsi_pkg::CFG_MIRROR:    ;
                default: ;
            endcase
        end
    end

    bmsi_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_address, .i_data,
        .i_chr_ram(r_chr == 6'd0), .o_q_valid(q_valid), .i_q_pop(q_pop),
        .o_q_req(q_req)
    );

    bmsi_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .i_prg_banks(r_prg), .i_chr_banks(r_chr), .i_variant(r_var),
        .i_mirror_load(cfg_wr && i_cfg_index == bmsi_pkg::CFG_MIRROR),
        .i_mirror_val(i_cfg_data[0]),
        .o_valid, .i_ready, .o_prg_offset, .o_cpu_unmapped, .o_chr_offset,
        .o_chr_uses_ram, .o_mirror_horizontal, .o_irq_line, .o_irq_taken
    );
endmodule

[rtl/bmsi_front.sv]
// Front end: accepts bus requests, classifies them and queues them for the back end.
// Depends on bmsi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bmsi_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [2:0]         i_mode,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_data,
    input  logic               i_chr_ram,
    output logic               o_q_valid,
    input  logic               i_q_pop,
    output bmsi_pkg::t_req     o_q_req
);
    bmsi_pkg::t_req r_q [bmsi_pkg::QDepth];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    bmsi_pkg::t_req n_req;
    logic           push;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_q[r_rp];

    always_comb begin
        n_req.address = i_address;
        n_req.data    = i_data;
        unique case (bmsi_pkg::t_mode'(i_mode))
            bmsi_pkg::MODE_CPU_RD: n_req.kind = i_address[15] ? bmsi_pkg::K_PRG
                                                              : bmsi_pkg::K_UNMAPPED;
            bmsi_pkg::MODE_CPU_WR: n_req.kind = bmsi_pkg::K_WRITE;
            bmsi_pkg::MODE_PPU_RD,
            bmsi_pkg::MODE_PPU_WR: n_req.kind = i_chr_ram ? bmsi_pkg::K_CHR_RAM
                                                          : bmsi_pkg::K_CHR;
            bmsi_pkg::MODE_TICK:   n_req.kind = bmsi_pkg::K_TICK;
            bmsi_pkg::MODE_POLL:   n_req.kind = bmsi_pkg::K_POLL;
            default:               n_req.kind = bmsi_pkg::K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= n_req;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

    `CHK_IMPL(a_no_pop_empty, i_q_pop, o_q_valid, "pop from empty queue")
    `CHK_IMPL(a_cnt_range, 1'b1, r_cnt != 2'd3, "queue count out of range")
endmodule

[rtl/bmsi_back.sv]
// Back end: mapper state, iterative bank modulo, result register.
// Depends on bmsi_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bmsi_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  bmsi_pkg::t_req     i_q_req,
    output logic               o_q_pop,
    input  logic [5:0]         i_prg_banks,
    input  logic [5:0]         i_chr_banks,
    input  logic               i_variant,
    input  logic               i_mirror_load,
    input  logic               i_mirror_val,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [18:0]        o_prg_offset,
    output logic               o_cpu_unmapped,
    output logic [17:0]        o_chr_offset,
    output logic               o_chr_uses_ram,
    output logic               o_mirror_horizontal,
    output logic               o_irq_line,
    output logic               o_irq_taken
);
    bmsi_pkg::t_state r_state, n_state;
    logic [7:0] r_sel, r_bank [8];
    logic       r_mirror, r_ren, r_rflag, r_pend;
    logic [7:0] r_latch, r_ctr;
    bmsi_pkg::t_req r_req;
    // restoring-free modulo: subtract shifted divisor, one bit per cycle
    logic [8:0]  r_rem;
    logic [8:0]  r_div;
    logic [2:0]  r_step;
    logic [15:0] dsh;
    logic [8:0]  n_div;
    logic [7:0]  bank_raw;
    logic        start, finish;
    logic [15:0] a;
    logic [12:0] pa;
    logic [6:0]  p8;
    logic [8:0]  c1k;
    logic [5:0]  pb_eff, cb_eff;
    logic [6:0]  page;
    logic [1:0]  slot;
    logic        need_mod;
    logic [15:0] dsh_cur;

    assign a = r_req.address;
    assign pb_eff = (i_prg_banks == 6'd0) ? 6'd1
                  : (i_prg_banks > 6'(bmsi_pkg::MaxPrgBanks)) ? 6'(bmsi_pkg::MaxPrgBanks)
                  : i_prg_banks;
    assign cb_eff = (i_chr_banks > 6'(bmsi_pkg::MaxChrBanks)) ? 6'(bmsi_pkg::MaxChrBanks)
                  : i_chr_banks;
    assign p8  = {pb_eff, 1'b0};
    assign c1k = {cb_eff, 3'b000};
    assign pa  = i_q_req.address[12:0] ^ {r_sel[7], 12'd0};
    assign slot = i_q_req.address[14:13];

    always_comb begin
        bank_raw = 8'd0;
        n_div    = 9'd0;
        need_mod = 1'b0;
        if (i_q_req.kind == bmsi_pkg::K_PRG) begin
            n_div = {2'b00, p8};
            need_mod = !(slot == 2'd3 || (slot[0] == 1'b0 && slot[1] != r_sel[6]));
            bank_raw = (slot == 2'd1) ? r_bank[7] : r_bank[6];
        end else if (i_q_req.kind == bmsi_pkg::K_CHR) begin
            n_div = c1k;
            need_mod = 1'b1;
            bank_raw = pa[12] ? r_bank[3'd2 + {1'b0, pa[11:10]}]
                              : (r_bank[{2'b00, pa[11]}] & 8'hFE);
        end
    end

    assign start   = (r_state == bmsi_pkg::S_IDLE) && i_q_valid;
    assign dsh_cur = {7'd0, r_div} << r_step;
    assign finish  = (r_state == bmsi_pkg::S_MOD) && (r_step == 3'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmsi_pkg::S_IDLE: if (i_q_valid) n_state = need_mod ? bmsi_pkg::S_MOD
                                                                : bmsi_pkg::S_DONE;
            bmsi_pkg::S_MOD:  if (r_step == 3'd0) n_state = bmsi_pkg::S_DONE;
            bmsi_pkg::S_DONE: if (!o_valid || i_ready) n_state = bmsi_pkg::S_IDLE;
            default:          n_state = bmsi_pkg::S_IDLE;
        endcase
    end

    assign o_q_pop = start;
    assign dsh = dsh_cur;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_req  <= i_q_req;
            r_rem  <= {1'b0, bank_raw};
            r_div  <= n_div;
            r_step <= 3'd7;
        end else if (r_state == bmsi_pkg::S_MOD) begin
            if ({7'd0, r_rem} >= dsh) r_rem <= r_rem - dsh[8:0];
            r_step <= r_step - 3'd1;
        end
    end

    // output and state update in S_DONE
    logic        fin_ok;
    logic [12:0] inner;
    logic [7:0]  ctr_nx;
    logic        mir_wr;
    logic [18:0] n_prg;
    logic [17:0] n_chr;
    logic        n_unm, n_ram, n_taken, n_pend;

    assign fin_ok = (r_state == bmsi_pkg::S_DONE) && (!o_valid || i_ready);
    assign mir_wr = (r_req.kind == bmsi_pkg::K_WRITE) && (a[15:13] == 3'b101)
                    && !a[0] && i_variant;

    always_comb begin
        page  = r_rem[6:0];
        if (r_req.kind == bmsi_pkg::K_PRG) begin
            if (a[14:13] == 2'd3) page = p8 - 7'd1;
            else if (a[13] == 1'b0 && a[14] != r_sel[6]) page = p8 - 7'd2;
        end
        inner = 13'(a[12:0] ^ {r_sel[7], 12'd0});
    end

    always_comb begin
        ctr_nx = (r_ctr == 8'd0 || r_rflag) ? r_latch : r_ctr - 8'd1;
    end

    always_comb begin
        n_prg   = 19'd0;
        n_unm   = 1'b0;
        n_chr   = 18'd0;
        n_ram   = 1'b0;
        n_taken = 1'b0;
        n_pend  = r_pend;
        unique case (r_req.kind)
            bmsi_pkg::K_PRG:      n_prg = {page[5:0], a[12:0]};
            bmsi_pkg::K_UNMAPPED: n_unm = 1'b1;
            bmsi_pkg::K_CHR:      n_chr = inner[12]
                ? {r_rem[7:0], inner[9:0]} : {r_rem[7:0], 10'd0} | {7'd0, inner[10:0]};
            bmsi_pkg::K_CHR_RAM: begin
                n_ram = 1'b1;
                n_chr = {5'd0, a[12:0]};
            end
            // even write in 0xE000-0xFFFF acknowledges
            bmsi_pkg::K_WRITE: if (a[15:13] == 3'b111 && !a[0]) n_pend = 1'b0;
            bmsi_pkg::K_TICK: if (i_variant && ctr_nx == 8'd0 && r_ren) n_pend = 1'b1;
            bmsi_pkg::K_POLL: begin
                n_taken = r_pend;
                n_pend  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmsi_pkg::S_IDLE;
            o_valid <= 1'b0;
            r_sel   <= 8'd0;
            for (int k = 0; k < 8; k++) r_bank[k] <= 8'd0;
            r_mirror <= 1'b0;
            r_latch  <= 8'd0;
            r_ctr    <= 8'd0;
            r_rflag  <= 1'b0;
            r_ren    <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fin_ok) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            if (i_mirror_load) r_mirror <= i_mirror_val;
            else if (fin_ok && mir_wr) r_mirror <= r_req.data[0];
            if (fin_ok) begin
                o_prg_offset   <= n_prg;
                o_cpu_unmapped <= n_unm;
                o_chr_offset   <= n_chr;
                o_chr_uses_ram <= n_ram;
                o_irq_taken    <= n_taken;
                o_irq_line     <= n_pend;
                r_pend         <= n_pend;
                unique case (r_req.kind)
                    bmsi_pkg::K_WRITE: begin
                        if (a[15]) begin
                            unique case (a[14:13])
                                2'd0: if (!a[0]) r_sel <= r_req.data;
                                      else r_bank[r_sel[2:0]] <= r_req.data;
                                2'd1: ;
                                2'd2: if (!a[0]) r_latch <= r_req.data;
                                      else begin r_ctr <= 8'd0; r_rflag <= 1'b1; end
                                default: r_ren <= a[0];
                            endcase
                        end
                    end
                    bmsi_pkg::K_TICK: if (i_variant) begin
                        r_ctr   <= ctr_nx;
                        r_rflag <= 1'b0;
                    end
                    default: ;
                endcase
            end
        end
    end

    // mirror output tracks state at result time
    logic r_mir_out;
    always_ff @(posedge i_clk) begin
        if (fin_ok) r_mir_out <= mir_wr ? r_req.data[0] : r_mirror;
    end
    assign o_mirror_horizontal = r_mir_out;

    `CHK_NEXT(a_hold, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `CHK_IMPL(a_pop_idle, o_q_pop, r_state == bmsi_pkg::S_IDLE, "pop outside idle")
    `CHK_NEXT(a_rem_lt, finish, r_rem < r_div, "remainder not below bank count")
endmodule
